// File: rtl/ppcfsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppcfsc_pkg
// Types and constants for the FP sign/select/compare/convert unit.
// ----------------------------------------------------------------------------
package ppcfsc_pkg;

   typedef enum logic [2:0] {
      OP_NEGATE  = 3'd0,
      OP_ABS     = 3'd1,
      OP_NEG_ABS = 3'd2,
      OP_FSEL    = 3'd3,
      OP_COMPARE = 3'd4,
      OP_CONVERT = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
      logic [63:0] operand_c;
      logic [2:0]  target_field;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic        writes_register;
      logic [3:0]  flags;
      logic [2:0]  flags_field;
      logic        writes_flags;
   } rsp_type;

   localparam logic [3:0]  FLAG_LT    = 4'b1000;
   localparam logic [3:0]  FLAG_GT    = 4'b0100;
   localparam logic [3:0]  FLAG_EQ    = 4'b0010;
   localparam logic [3:0]  FLAG_UN    = 4'b0001;
   localparam logic [63:0] CONV_BASE  = 64'hFFF8_0000_0000_0000;
   localparam logic [31:0] INT_MIN    = 32'h8000_0000;
   localparam logic [31:0] INT_MAX    = 32'h7FFF_FFFF;
   localparam logic [10:0] EXP_BIAS   = 11'd1023;
   localparam logic [10:0] EXP_SAT    = 11'd1054;

   function automatic logic is_nan(input logic [63:0] x);
      return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
   endfunction

   function automatic logic is_zero(input logic [62:0] x);
      return x == 63'd0;
   endfunction

endpackage
`default_nettype wire

// File: rtl/ppcfsc_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppcfsc_exec
// Combinational datapath: sign ops, select, compare and truncating convert.
// ----------------------------------------------------------------------------
module ppcfsc_exec (
   input  var ppcfsc_pkg::req_type req,
   output var ppcfsc_pkg::rsp_type rsp
);

   logic [63:0] a, b, ka, kb, conv;
   logic        nan_a, nan_b, neg;
   logic [10:0] ex;
   logic [4:0]  e5;
   logic [83:0] shifted;
   logic [31:0] m32, val;
   logic [3:0]  cmp;

   always_comb begin
      a     = req.operand_a;
      b     = req.operand_b;
      nan_a = ppcfsc_pkg::is_nan(a);
      nan_b = ppcfsc_pkg::is_nan(b);
      ka    = a[63] ? ~a : (a | {1'b1, 63'd0});
      kb    = b[63] ? ~b : (b | {1'b1, 63'd0});
      if (nan_a || nan_b) begin
         cmp = ppcfsc_pkg::FLAG_UN;
      end else if (ppcfsc_pkg::is_zero(a[62:0]) && ppcfsc_pkg::is_zero(b[62:0])) begin
         cmp = ppcfsc_pkg::FLAG_EQ;
      end else if (ka < kb) begin
         cmp = ppcfsc_pkg::FLAG_LT;
      end else if (ka > kb) begin
         cmp = ppcfsc_pkg::FLAG_GT;
      end else begin
         cmp = ppcfsc_pkg::FLAG_EQ;
      end

      neg     = b[63];
      ex      = b[62:52];
      e5      = 5'(ex - ppcfsc_pkg::EXP_BIAS);
      shifted = {31'd0, 1'b1, b[51:0]} << e5;
      m32     = shifted[83:52];
      if (nan_b) begin
         val = ppcfsc_pkg::INT_MIN;
      end else if (ex < ppcfsc_pkg::EXP_BIAS) begin
         val = 32'd0;
      end else if (ex >= ppcfsc_pkg::EXP_SAT) begin
         val = neg ? ppcfsc_pkg::INT_MIN : ppcfsc_pkg::INT_MAX;
      end else begin
         val = neg ? (32'd0 - m32) : m32;
      end
      conv = ppcfsc_pkg::CONV_BASE | {32'd0, val};
      if (val == 32'd0 && neg) begin
         conv[32] = 1'b1;
      end

      rsp.result          = 64'd0;
      rsp.writes_register = 1'b1;
      rsp.flags           = 4'd0;
      rsp.flags_field     = req.target_field;
      rsp.writes_flags    = 1'b0;
      case (req.operation)
         ppcfsc_pkg::OP_NEGATE:  rsp.result = {~b[63], b[62:0]};
         ppcfsc_pkg::OP_ABS:     rsp.result = {1'b0, b[62:0]};
         ppcfsc_pkg::OP_NEG_ABS: rsp.result = {1'b1, b[62:0]};
         ppcfsc_pkg::OP_FSEL: begin
            rsp.result = (!nan_a && (!a[63] || ppcfsc_pkg::is_zero(a[62:0])))
                         ? req.operand_c : b;
         end
         ppcfsc_pkg::OP_COMPARE: begin
            rsp.writes_register = 1'b0;
            rsp.flags           = cmp;
            rsp.writes_flags    = 1'b1;
         end
         ppcfsc_pkg::OP_CONVERT: rsp.result = conv;
         default: rsp.writes_register = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/ppc_fp_sign_select_compare_convert_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_fp_sign_select_compare_convert_top
// FP sign/select/compare/truncating-convert unit on raw double words.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel takes one operation word (op, a, b, c, CR field) under
//   valid/ready; rsp_ channel returns one result word per request.
//   Request is captured in an input register, evaluated by one level of
//   combinational logic, and held in a result register that drives
//   rsp_valid; throughput 1 word per cycle while the receiver keeps
//   rsp_ready high.
//   Each stage advances when the stage after it is empty or being
//   drained, so a stalled receiver backs up into req_ready.
//   Reset clears both stage valids; no words are in flight afterwards.
// ----------------------------------------------------------------------------
module ppc_fp_sign_select_compare_convert_top (
   input  var logic                clock,
   input  var logic                reset,
   input  var logic                req_valid,
   output var logic                req_ready,
   input  var ppcfsc_pkg::req_type req_data,
   output var logic                rsp_valid,
   input  var logic                rsp_ready,
   output var ppcfsc_pkg::rsp_type rsp_data
);

   ppcfsc_pkg::req_type req_ff;
   ppcfsc_pkg::rsp_type rsp_ff, rsp_in;
   logic in_vld_ff, out_vld_ff, adv_out, adv_in;

   ppcfsc_exec u_exec (.req(req_ff), .rsp(rsp_in));

   assign adv_out   = !out_vld_ff || rsp_ready;
   assign adv_in    = !in_vld_ff || adv_out;
   assign req_ready = adv_in;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv_in) in_vld_ff <= req_valid;
         if (adv_out) out_vld_ff <= in_vld_ff;
      end
      if (adv_in && req_valid) req_ff <= req_data;
      if (adv_out && in_vld_ff) rsp_ff <= rsp_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped under stall");
   a_full: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_ready |-> !req_ready)
      else $error("accepted while full");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.writes_flags && rsp_data.writes_register))
      else $error("both write enables set");

endmodule
`default_nettype wire
